// ===== hdl/rfda_pkg.sv =====
// Package for the radial falloff damage accumulator.
// Types and constants shared by the top level; no dependencies.
package rfda_pkg;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_QUERY = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_DX,
      ST_DY,
      ST_DZ,
      ST_CMP,
      ST_SQRT,
      ST_DIV,
      ST_MUL,
      ST_ACC,
      ST_NEXT,
      ST_OUT
   } state_type;

   localparam logic [39:0] TOTAL_MAX = 40'hFF_FFFF_FFFF;
   localparam logic [16:0] ONE_Q16   = 17'h1_0000;

endpackage

// ===== hdl/radial_falloff_damage_accumulator.sv =====
// Radial falloff damage accumulator, top level.
// Depends on rfda_pkg; holds the source table as internal memories.
//
// One transfer in, one result transfer out. Add, clear and the unused action
// go from idle to the output state, and the result valid flag is registered
// from there. A query walks the stored sources one after another. A source
// whose category misses the mask passes the next, fetch and load states. One
// that fails the range check goes on through the DX, DY and DZ squaring states
// and the compare. One that is in range then takes the square root (one result
// bit per cycle), the restoring divide (one quotient bit a cycle), the multiply
// and the accumulate. The shared units are a 33x33 squarer, a one-bit-per-cycle
// square root and a one-bit-per-cycle divider.
// The source table is one memory per field with a registered read. No clearing
// pass is needed, because the fill count bounds reads.
// req_ready is low while an item is at work or its result waits.
module radial_falloff_damage_accumulator #(
   parameter int MAX_SOURCES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [15:0]        req_source_category,
   input  logic [15:0]        req_query_mask,
   input  logic [31:0]        req_radius,
   input  logic [31:0]        req_damage,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [39:0]        rsp_total_damage,
   output logic signed [31:0] rsp_closest_x,
   output logic signed [31:0] rsp_closest_y,
   output logic signed [31:0] rsp_closest_z,
   output logic               rsp_hit,
   output logic               rsp_add_dropped
);

   localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int CW = $clog2(MAX_SOURCES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SOURCES);

   // source table
   logic [31:0] mem_x   [MAX_SOURCES];
   logic [31:0] mem_y   [MAX_SOURCES];
   logic [31:0] mem_z   [MAX_SOURCES];
   logic [15:0] mem_cat [MAX_SOURCES];
   logic [31:0] mem_rad [MAX_SOURCES];
   logic [31:0] mem_dmg [MAX_SOURCES];

   logic [31:0] rd_x, rd_y, rd_z, rd_rad, rd_dmg;
   logic [15:0] rd_cat;

   rfda_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          wr_en;

   // query operands
   logic [31:0] qx_ff, qy_ff, qz_ff;
   logic [15:0] mask_ff;
   logic [31:0] sx_ff, sy_ff, sz_ff, rad_ff, dmg_ff;
   logic [15:0] cat_ff;

   // shared arithmetic state
   logic [65:0] s_ff, s_in;          // squared length, with overflow room
   logic [63:0] rem_ff, rem_in;      // square root remainder / divide remainder
   logic [31:0] root_ff, root_in;    // distance
   logic [47:0] num_ff, num_in;      // dividend shifted out
   logic [16:0] quo_ff, quo_in;
   logic [5:0]  step_ff, step_in;
   logic [63:0] prod_ff, prod_in;

   logic [39:0] total_ff, total_in;
   logic        any_ff, any_in;
   logic [31:0] best_ff, best_in;
   logic [31:0] cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   logic        drop_ff, drop_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // squarer operand select
   logic [31:0] sq_a, sq_b;
   logic signed [32:0] diff;
   logic [32:0] mag;
   logic [65:0] sq;

   // square root trial and divide trial
   logic [65:0] trial_rem;
   logic [65:0] trial_sub;
   logic [32:0] div_rem;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[count_ff[AW-1:0]]   <= req_pos_x;
         mem_y[count_ff[AW-1:0]]   <= req_pos_y;
         mem_z[count_ff[AW-1:0]]   <= req_pos_z;
         mem_cat[count_ff[AW-1:0]] <= req_source_category;
         mem_rad[count_ff[AW-1:0]] <= req_radius;
         mem_dmg[count_ff[AW-1:0]] <= req_damage;
      end
      rd_x   <= mem_x[idx_ff[AW-1:0]];
      rd_y   <= mem_y[idx_ff[AW-1:0]];
      rd_z   <= mem_z[idx_ff[AW-1:0]];
      rd_cat <= mem_cat[idx_ff[AW-1:0]];
      rd_rad <= mem_rad[idx_ff[AW-1:0]];
      rd_dmg <= mem_dmg[idx_ff[AW-1:0]];
   end

   always_comb begin
      case (state_ff)
         rfda_pkg::ST_DY: begin sq_a = qy_ff; sq_b = sy_ff; end
         rfda_pkg::ST_DZ: begin sq_a = qz_ff; sq_b = sz_ff; end
         default:         begin sq_a = qx_ff; sq_b = sx_ff; end
      endcase
      diff = $signed({sq_a[31], sq_a}) - $signed({sq_b[31], sq_b});
      mag  = diff[32] ? 33'(-diff) : 33'(diff);
      sq   = 66'(mag) * 66'(mag);
   end

   // sqrt: classic digit-by-digit, one result bit per cycle over 32 steps
   assign trial_rem = {rem_ff, s_ff[63:62]};
   assign trial_sub = trial_rem - {32'd0, root_ff, 2'b01};
   // divide: remainder vs radius, one quotient bit per cycle
   assign div_rem   = {rem_ff[31:0], num_ff[47]};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      wr_en        = 1'b0;
      s_in         = s_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      total_in     = total_ff;
      any_in       = any_ff;
      best_in      = best_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff;
      req_ready    = (state_ff == rfda_pkg::ST_IDLE) && !rsp_valid_ff;

      case (state_ff)
         rfda_pkg::ST_IDLE: begin
            if (req_valid && req_ready) begin
               total_in = '0;
               any_in   = 1'b0;
               drop_in  = 1'b0;
               cx_in    = '0;
               cy_in    = '0;
               cz_in    = '0;
               idx_in   = '0;
               case (rfda_pkg::action_type'(req_action))
                  rfda_pkg::ACT_ADD: begin
                     if (count_ff >= MAX_CNT) begin
                        drop_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                     state_in = rfda_pkg::ST_OUT;
                  end
                  rfda_pkg::ACT_CLEAR: begin
                     count_in = '0;
                     state_in = rfda_pkg::ST_OUT;
                  end
                  rfda_pkg::ACT_QUERY: begin
                     cx_in    = req_pos_x;
                     cy_in    = req_pos_y;
                     cz_in    = req_pos_z;
                     state_in = rfda_pkg::ST_NEXT;
                  end
                  default: state_in = rfda_pkg::ST_OUT;
               endcase
            end
         end
         rfda_pkg::ST_NEXT: begin
            if (idx_ff >= count_ff) state_in = rfda_pkg::ST_OUT;
            else                    state_in = rfda_pkg::ST_FETCH;
         end
         rfda_pkg::ST_FETCH: state_in = rfda_pkg::ST_LOAD;   // memory read
         rfda_pkg::ST_LOAD: begin
            if ((cat_ff & mask_ff) == '0) begin
               idx_in   = idx_ff + 1'b1;
               state_in = rfda_pkg::ST_NEXT;
            end else begin
               state_in = rfda_pkg::ST_DX;
            end
         end
         rfda_pkg::ST_DX: begin
            s_in = sq;
            state_in = rfda_pkg::ST_DY;
         end
         rfda_pkg::ST_DY: begin
            s_in = s_ff + sq;
            state_in = rfda_pkg::ST_DZ;
         end
         rfda_pkg::ST_DZ: begin
            s_in = s_ff + sq;
            prod_in = 64'(rad_ff) * 64'(rad_ff);
            state_in = rfda_pkg::ST_CMP;
         end
         rfda_pkg::ST_CMP: begin
            // overflow past 64 bits, or outside radius: no contribution
            if (s_ff[65:64] != 2'b00 || s_ff[63:0] >= prod_ff) begin
               idx_in   = idx_ff + 1'b1;
               state_in = rfda_pkg::ST_NEXT;
            end else begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = rfda_pkg::ST_SQRT;
            end
         end
         rfda_pkg::ST_SQRT: begin
            if (!trial_sub[65]) begin
               rem_in  = trial_sub[63:0];
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               rem_in  = trial_rem[63:0];
               root_in = {root_ff[30:0], 1'b0};
            end
            s_in    = {s_ff[65:64], s_ff[61:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == 6'd31) begin
               num_in   = {root_in, 16'd0};
               rem_in   = '0;
               quo_in   = '0;
               step_in  = '0;
               state_in = rfda_pkg::ST_DIV;
            end
         end
         rfda_pkg::ST_DIV: begin
            // quotient < 2^16 since d < r; keep low 17 bits
            if (div_rem >= {1'b0, rad_ff}) begin
               rem_in = 64'(div_rem - {1'b0, rad_ff});
               quo_in = {quo_ff[15:0], 1'b1};
            end else begin
               rem_in = 64'(div_rem);
               quo_in = {quo_ff[15:0], 1'b0};
            end
            num_in  = {num_ff[46:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == 6'd47) state_in = rfda_pkg::ST_MUL;
         end
         rfda_pkg::ST_MUL: begin
            prod_in  = 64'(dmg_ff) * 64'(rfda_pkg::ONE_Q16 - quo_ff);
            if (!any_ff || root_ff < best_ff) begin
               any_in  = 1'b1;
               best_in = root_ff;
               cx_in   = sx_ff;
               cy_in   = sy_ff;
               cz_in   = sz_ff;
            end
            state_in = rfda_pkg::ST_ACC;
         end
         rfda_pkg::ST_ACC: begin
            if ({1'b0, total_ff} + 41'(prod_ff[63:16]) > 41'(rfda_pkg::TOTAL_MAX))
               total_in = rfda_pkg::TOTAL_MAX;
            else
               total_in = total_ff + 40'(prod_ff[63:16]);
            idx_in   = idx_ff + 1'b1;
            state_in = rfda_pkg::ST_NEXT;
         end
         rfda_pkg::ST_OUT: begin
            rsp_valid_in = 1'b1;
            state_in     = rfda_pkg::ST_IDLE;
         end
         default: state_in = rfda_pkg::ST_IDLE;
      endcase
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfda_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      s_ff     <= s_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      num_ff   <= num_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      prod_ff  <= prod_in;
      total_ff <= total_in;
      any_ff   <= any_in;
      best_ff  <= best_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      drop_ff  <= drop_in;
      if (state_ff == rfda_pkg::ST_IDLE && req_valid && req_ready) begin
         qx_ff   <= req_pos_x;
         qy_ff   <= req_pos_y;
         qz_ff   <= req_pos_z;
         mask_ff <= req_query_mask;
      end
      if (state_ff == rfda_pkg::ST_FETCH) begin
         sx_ff  <= rd_x;
         sy_ff  <= rd_y;
         sz_ff  <= rd_z;
         cat_ff <= rd_cat;
         rad_ff <= rd_rad;
         dmg_ff <= rd_dmg;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_total_damage = total_ff;
   assign rsp_closest_x    = cx_ff;
   assign rsp_closest_y    = cy_ff;
   assign rsp_closest_z    = cz_ff;
   assign rsp_hit          = any_ff;
   assign rsp_add_dropped  = drop_ff;

   // fill count never exceeds the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT) else $error("source count beyond table");

   // a result only waits while the sequencer is idle
   a_out_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == rfda_pkg::ST_IDLE) else $error("busy with result");

   // no hit means no damage
   a_hit_total: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !any_ff) |-> total_ff == '0) else $error("damage without hit");

endmodule

// ===== test/radial_falloff_damage_accumulator_tb.sv =====
// Testbench for the radial falloff damage accumulator.
// Depends on rfda_pkg and the top level; predicts each result and checks it field by field.
module radial_falloff_damage_accumulator_tb;

   localparam int TABLE_DEPTH = 64;
   localparam int CYCLE_LIMIT = 20_000_000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = rfda_pkg::ACT_ADD;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [15:0]        req_source_category = '0, req_query_mask = '0;
   logic [31:0]        req_radius = '0, req_damage = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [39:0]        rsp_total_damage;
   logic signed [31:0] rsp_closest_x, rsp_closest_y, rsp_closest_z;
   logic               rsp_hit, rsp_add_dropped;

   radial_falloff_damage_accumulator uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic [39:0] total;
      logic [31:0] cx, cy, cz;
      logic        hit;
      logic        dropped;
   } damage_report_type;

   // predictor's own copy of the source table
   int unsigned  n_sources;
   logic [31:0]  tab_x[TABLE_DEPTH], tab_y[TABLE_DEPTH], tab_z[TABLE_DEPTH];
   logic [15:0]  tab_cat[TABLE_DEPTH];
   logic [31:0]  tab_rad[TABLE_DEPTH], tab_dmg[TABLE_DEPTH];

   damage_report_type pending_reports[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  quiet_rx = 0;     // no random stalls on the result side
   bit  quiet_tx = 0;     // no random gaps on the request side
   int  hold_rsp = 0;     // cycles of forced receiver hold-off

   function automatic logic [63:0] abs_diff_sq(logic [31:0] a, logic [31:0] b);
      logic signed [33:0] d;
      logic [32:0] m;
      d = $signed({a[31], a}) - $signed({b[31], b});
      m = d[33] ? 33'(-d) : 33'(d);
      return 64'(m) * 64'(m);
   endfunction

   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic damage_report_type apply_action(logic [1:0] act, logic [31:0] px,
         logic [31:0] py, logic [31:0] pz, logic [15:0] cat, logic [15:0] mask,
         logic [31:0] rad, logic [31:0] dmg);
      damage_report_type r;
      logic [65:0] s;
      logic [63:0] d, best, q, rr;
      logic [47:0] contrib;
      logic [40:0] tot;
      r = '0;
      case (act)
         rfda_pkg::ACT_ADD: begin
            if (n_sources >= TABLE_DEPTH) begin
               r.dropped = 1'b1;
            end else begin
               tab_x[n_sources] = px; tab_y[n_sources] = py; tab_z[n_sources] = pz;
               tab_cat[n_sources] = cat; tab_rad[n_sources] = rad;
               tab_dmg[n_sources] = dmg;
               n_sources++;
            end
         end
         rfda_pkg::ACT_CLEAR: n_sources = 0;
         rfda_pkg::ACT_QUERY: begin
            tot = 0; best = 0;
            r.cx = px; r.cy = py; r.cz = pz;
            for (int i = 0; i < n_sources; i++) begin
               if ((tab_cat[i] & mask) == 0) continue;
               s = 66'(abs_diff_sq(px, tab_x[i])) + 66'(abs_diff_sq(py, tab_y[i]))
                   + 66'(abs_diff_sq(pz, tab_z[i]));
               if (s[65:64] != 2'b00) continue;   // far source, sum overflows
               rr = 64'(tab_rad[i]) * 64'(tab_rad[i]);
               if (s[63:0] >= rr) continue;    // out of range or zero radius
               d = floor_root(s[63:0]);
               if (!r.hit || d < best) begin
                  r.hit = 1'b1; best = d;
                  r.cx = tab_x[i]; r.cy = tab_y[i]; r.cz = tab_z[i];
               end
               q = (d << 16) / 64'(tab_rad[i]);
               contrib = 48'((64'(tab_dmg[i]) * (64'd65536 - q)) >> 16);
               tot = tot + 41'(contrib);
               if (tot > 41'(rfda_pkg::TOTAL_MAX)) tot = 41'(rfda_pkg::TOTAL_MAX);
            end
            r.total = tot[39:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   // one transfer on the request side; predicts at acceptance.
   // Entered and left at a falling edge; valid drops only when the sender idles.
   task automatic send_request(logic [1:0] act, logic [31:0] px, logic [31:0] py,
         logic [31:0] pz, logic [15:0] cat, logic [15:0] mask, logic [31:0] rad,
         logic [31:0] dmg);
      while (!quiet_tx && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1; req_action <= act;
      req_pos_x <= px; req_pos_y <= py; req_pos_z <= pz;
      req_source_category <= cat; req_query_mask <= mask;
      req_radius <= rad; req_damage <= dmg;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_reports.push_back(apply_action(act, px, py, pz, cat, mask, rad, dmg));
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000)) - 1000) << 16;
         default: return 32'($signed($urandom_range(200000)) - 100000) << 4;
      endcase
   endfunction

   task automatic add_random(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
      logic [31:0] rad;
      rad = ($urandom_range(9) == 0) ? $urandom : ($urandom_range(1, 3000) << 12);
      if ($urandom_range(19) == 0) rad = 0;
      send_request(rfda_pkg::ACT_ADD, cx + ($urandom_range(1 << 22) - (1 << 21)),
                   cy + ($urandom_range(1 << 22) - (1 << 21)),
                   cz + ($urandom_range(1 << 22) - (1 << 21)),
                   16'($urandom), 16'($urandom), rad, $urandom);
   endtask

   task automatic query_random(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
      send_request(rfda_pkg::ACT_QUERY, cx + ($urandom_range(1 << 23) - (1 << 22)),
                   cy + ($urandom_range(1 << 23) - (1 << 22)),
                   cz + ($urandom_range(1 << 23) - (1 << 22)),
                   16'($urandom), ($urandom_range(4) == 0) ? 16'(1 << $urandom_range(15))
                   : 16'($urandom), $urandom, $urandom);
   endtask

   // receiver
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_rsp > 0) begin
         rsp_ready <= 1'b0;
         hold_rsp <= hold_rsp - 1;
      end else rsp_ready <= quiet_rx || ($urandom_range(99) >= 17);
   end

   // result checker
   always @(posedge clock) begin
      damage_report_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("result transfer with nothing expected");
            fail_count = fail_count + 1;
         end else begin
            e = pending_reports.pop_front();
            if (rsp_total_damage !== e.total) begin
               $error("total_damage exp %h got %h", e.total, rsp_total_damage);
               fail_count = fail_count + 1;
            end
            if (rsp_closest_x !== e.cx) begin
               $error("closest_x exp %h got %h", e.cx, rsp_closest_x);
               fail_count = fail_count + 1;
            end
            if (rsp_closest_y !== e.cy) begin
               $error("closest_y exp %h got %h", e.cy, rsp_closest_y);
               fail_count = fail_count + 1;
            end
            if (rsp_closest_z !== e.cz) begin
               $error("closest_z exp %h got %h", e.cz, rsp_closest_z);
               fail_count = fail_count + 1;
            end
            if (rsp_hit !== e.hit) begin
               $error("hit exp %b got %b", e.hit, rsp_hit);
               fail_count = fail_count + 1;
            end
            if (rsp_add_dropped !== e.dropped) begin
               $error("add_dropped exp %b got %b", e.dropped, rsp_add_dropped);
               fail_count = fail_count + 1;
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // extremes of fields, every action, zero radius, far sources
   task automatic test_directed();
      send_request(rfda_pkg::ACT_QUERY, 0, 0, 0, 0, 16'hFFFF, 0, 0);    // empty table
      send_request(rfda_pkg::ACT_ADD, 32'h0001_0000, 0, 0, 16'h0001, 0, 32'h0004_0000,
                   32'hFFFF_FFFF);
      send_request(rfda_pkg::ACT_ADD, 32'hFFFF_0000, 0, 0, 16'h0001, 0, 32'h0004_0000,
                   32'h0001_0000);
      send_request(rfda_pkg::ACT_ADD, 0, 0, 0, 16'hFFFF, 0, 0, 32'hFFFF_FFFF);  // zero radius
      send_request(rfda_pkg::ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   16'h8000, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(rfda_pkg::ACT_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   16'h8000, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(rfda_pkg::ACT_QUERY, 0, 0, 0, 16'h0001, 0, 0, 0);    // category set but mask empty
      send_request(rfda_pkg::ACT_QUERY, 0, 0, 0, 16'h0000, 0, 0, 0);    // empty mask
      send_request(rfda_pkg::ACT_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   16'h8000, 0, 0, 0);
      send_request(rfda_pkg::ACT_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // far source
      send_request(rfda_pkg::ACT_NONE, 32'h1234_5678, 1, 2, 16'hFFFF, 16'hFFFF, 5, 6);
      send_request(rfda_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(rfda_pkg::ACT_QUERY, 5, 6, 7, 16'hFFFF, 16'hFFFF, 0, 0);
   endtask

   // full table: many big sources on one spot, then one add that is dropped
   task automatic test_saturation();
      repeat (TABLE_DEPTH) send_request(rfda_pkg::ACT_ADD, 0, 0, 0, 16'hFFFF, 0,
                                        32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(rfda_pkg::ACT_ADD, 1, 2, 3, 16'hFFFF, 0, 32'h10000, 32'h10000); // dropped
      send_request(rfda_pkg::ACT_QUERY, 0, 0, 0, 16'hFFFF, 0, 0, 0);
      send_request(rfda_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
   endtask

   // random clusters of sources with queries near them
   task automatic test_random(int n_items);
      logic [31:0] cx, cy, cz;
      int sent;
      sent = 0;
      while (sent < n_items) begin
         cx = rand_coord(); cy = rand_coord(); cz = rand_coord();
         if ($urandom_range(9) == 0) begin
            send_request(rfda_pkg::ACT_CLEAR, $urandom, $urandom, $urandom,
                         16'($urandom), 16'($urandom), $urandom, $urandom);
            sent++;
         end
         repeat ($urandom_range(1, 10)) begin add_random(cx, cy, cz); sent++; end
         repeat ($urandom_range(1, 4)) begin query_random(cx, cy, cz); sent++; end
         if ($urandom_range(29) == 0) begin
            send_request(rfda_pkg::ACT_NONE, $urandom, $urandom, $urandom,
                         16'($urandom), 16'($urandom), $urandom, $urandom);
            sent++;
         end
      end
   endtask

   // receiver holds off while requests keep coming, so the block stalls
   task automatic test_backpressure();
      hold_rsp = 300;
      repeat (6) query_random(0, 0, 0);
   endtask

   task automatic test_no_idling();
      quiet_tx = 1; quiet_rx = 1;
      test_random(60);
      quiet_tx = 0; quiet_rx = 0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      n_sources = 0;
      test_directed();
      test_saturation();
      test_random(200);
      test_backpressure();
      test_no_idling();
      test_random(200);
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
